// ===== rtl/multi_timer_expiry_engine_macros.svh =====
// ----------------------------------------------------------------------------
// Multi-timer expiry engine assertion macros
// Checks clocked on clk; MTE_ASSERT checks are held off during rst, MTE_ASSERT_ALWAYS checks are not.
// ----------------------------------------------------------------------------
`ifndef MULTI_TIMER_EXPIRY_ENGINE_MACROS_SVH
`define MULTI_TIMER_EXPIRY_ENGINE_MACROS_SVH

`ifndef SYNTH

// implication check, masked while in reset
`define MTE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("multi_timer_expiry_engine: check failed");

// check that also holds during reset
`define MTE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("multi_timer_expiry_engine: check failed");

`else

`define MTE_ASSERT(lbl, prop)
`define MTE_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ===== rtl/mte_pkg.sv =====
// ----------------------------------------------------------------------------
// mte_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package mte_pkg;

  localparam int MAX_TIMERS = 16;
  localparam int CNT_W      = $clog2(MAX_TIMERS + 1);
  localparam int IDX_W      = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int TIME_W     = 32;
  localparam int HANDLE_W   = 8;

  localparam logic OP_ADD     = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  localparam logic [1:0] KIND_ADDED = 2'd0;
  localparam logic [1:0] KIND_FULL  = 2'd1;
  localparam logic [1:0] KIND_FIRED = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  typedef struct packed {
    logic add;       // insert new timer at front, report
    logic adv_load;  // latch elapsed, start table walk
    logic step;      // examine one table entry
    logic finish;    // report final advance result
  } mte_cmd_t;

  typedef struct packed {
    logic walk_end;  // walk index has reached the timer count
  } mte_status_t;

endpackage

// ===== rtl/mte_ctrl.sv =====
// ----------------------------------------------------------------------------
// mte_ctrl
// Request sequencer: adds taken straight from idle, advance run as a table walk.
// ----------------------------------------------------------------------------
module mte_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                operation,
  input  mte_pkg::mte_status_t status,
  output mte_pkg::mte_cmd_t   cmd,
  output logic                busy
);
  import mte_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (operation == OP_ADD) begin
            cmd.add = 1'b1;
          end else begin
            cmd.adv_load = 1'b1;
            state_next   = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (status.walk_end) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next == S_WALK);
    end
  end

endmodule

// ===== rtl/mte_datapath.sv =====
// ----------------------------------------------------------------------------
// mte_datapath
// Timer table (newest first), walk unit, running minimum, result registers.
// ----------------------------------------------------------------------------
module mte_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  mte_pkg::mte_cmd_t               cmd,
  input  logic [mte_pkg::TIME_W-1:0]      interval,
  input  logic                            repeat_req,
  input  logic [mte_pkg::HANDLE_W-1:0]    handle,
  input  logic [mte_pkg::TIME_W-1:0]      elapsed,
  output mte_pkg::mte_status_t            status,
  output logic                            strobe,
  output logic [1:0]                      kind,
  output logic [mte_pkg::HANDLE_W-1:0]    fired_handle,
  output logic                            has_timer,
  output logic [mte_pkg::TIME_W-1:0]      next_timeout,
  output logic                            last
);
  import mte_pkg::*;

  // table storage, slot 0 newest; valid slots are [0, count)
  logic [TIME_W-1:0]   rem [MAX_TIMERS];
  logic [TIME_W-1:0]   per [MAX_TIMERS];
  logic                rep [MAX_TIMERS];
  logic [HANDLE_W-1:0] own [MAX_TIMERS];

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  idx;
  logic [TIME_W-1:0] el;
  logic [TIME_W-1:0] cur_min;   // min remaining over the whole table
  logic [TIME_W-1:0] run_min;   // min over survivors seen in this walk

  logic [IDX_W-1:0]  sel;
  logic [TIME_W-1:0] rt;
  logic              survive;
  logic              full;
  logic [TIME_W-1:0] kept_val;
  logic [TIME_W-1:0] add_min;
  logic              remove;

  assign sel      = idx[IDX_W-1:0];
  assign rt       = rem[sel];
  assign survive  = (rt > el);
  assign kept_val = survive ? (rt - el) : per[sel];
  assign remove   = cmd.step && !survive && !rep[sel];
  assign full     = (count == CNT_W'(MAX_TIMERS));
  assign add_min  = ((count == '0) || (interval < cur_min)) ? interval : cur_min;

  assign status.walk_end = (idx == count);

  // control and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      idx    <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.add || (cmd.step && !survive) || cmd.finish;
      if (cmd.add) begin
        if (!full) begin
          count <= count + CNT_W'(1);
        end
      end
      if (cmd.adv_load) begin
        idx <= '0;
      end
      if (cmd.step) begin
        if (remove) begin
          count <= count - CNT_W'(1);
        end else begin
          idx <= idx + CNT_W'(1);
        end
      end
    end
  end

  // table contents and running values
  always_ff @(posedge clk) begin
    if (cmd.add && !full) begin
      for (int i = MAX_TIMERS - 1; i > 0; i--) begin
        rem[i] <= rem[i-1];
        per[i] <= per[i-1];
        rep[i] <= rep[i-1];
        own[i] <= own[i-1];
      end
      rem[0]  <= interval;
      per[0]  <= interval;
      rep[0]  <= repeat_req;
      own[0]  <= handle;
      cur_min <= add_min;
    end
    if (cmd.adv_load) begin
      el      <= elapsed;
      run_min <= '1;
    end
    if (cmd.step) begin
      if (remove) begin
        // one-shot expired: close up the entries behind it
        for (int j = 0; j < MAX_TIMERS - 1; j++) begin
          if (CNT_W'(j) >= idx) begin
            rem[j] <= rem[j+1];
            per[j] <= per[j+1];
            rep[j] <= rep[j+1];
            own[j] <= own[j+1];
          end
        end
      end else begin
        rem[sel] <= kept_val;
        if (kept_val < run_min) begin
          run_min <= kept_val;
        end
      end
    end
    if (cmd.finish) begin
      cur_min <= run_min;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.add) begin
      kind         <= full ? KIND_FULL : KIND_ADDED;
      fired_handle <= '0;
      has_timer    <= 1'b1;
      next_timeout <= full ? cur_min : add_min;
      last         <= 1'b1;
    end else if (cmd.step) begin
      kind         <= KIND_FIRED;
      fired_handle <= own[sel];
      has_timer    <= 1'b0;
      next_timeout <= '0;
      last         <= 1'b0;
    end else if (cmd.finish) begin
      kind         <= KIND_DONE;
      fired_handle <= '0;
      has_timer    <= (count != '0);
      next_timeout <= (count != '0) ? run_min : '0;
      last         <= 1'b1;
    end
  end

endmodule

// ===== rtl/multi_timer_expiry_engine.sv =====
// ----------------------------------------------------------------------------
// multi_timer_expiry_engine
// Table of up to MAX_TIMERS one-shot or periodic timers with expiry reporting.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. An add request gives
// its result (added or table full) in the cycle after it is taken, and busy
// stays low, so adds may follow back to back. An advance request holds busy
// until its walk of the table is done: a single compare/subtract unit
// examines one table entry per cycle, newest first. Each expiring timer gives
// a fired result in the cycle after it is examined, and the closing
// advance-done result follows the walk. Results are shown for one cycle under
// strobe and cannot be held off, so the receiver must take every strobed
// cycle. Reset leaves the table empty with no clearing pass.
module multi_timer_expiry_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         operation,
  input  logic [mte_pkg::TIME_W-1:0]   interval,
  input  logic                         repeat_req,
  input  logic [mte_pkg::HANDLE_W-1:0] handle,
  input  logic [mte_pkg::TIME_W-1:0]   elapsed,
  output logic                         strobe,
  output logic [1:0]                   kind,
  output logic [mte_pkg::HANDLE_W-1:0] fired_handle,
  output logic                         has_timer,
  output logic [mte_pkg::TIME_W-1:0]   next_timeout,
  output logic                         last
);
  import mte_pkg::*;

`include "multi_timer_expiry_engine_macros.svh"

  mte_cmd_t    cmd;
  mte_status_t status;

  mte_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start && !busy),
    .operation (operation),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  mte_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .interval     (interval),
    .repeat_req   (repeat_req),
    .handle       (handle),
    .elapsed      (elapsed),
    .status       (status),
    .strobe       (strobe),
    .kind         (kind),
    .fired_handle (fired_handle),
    .has_timer    (has_timer),
    .next_timeout (next_timeout),
    .last         (last)
  );

  // an add request reports in the very next cycle
  `MTE_ASSERT(a_add_reports, (start && !busy && operation == OP_ADD) |=> (strobe && last))
  // end of walk gives the advance-done result
  `MTE_ASSERT(a_walk_done, (cmd.finish) |=> (strobe && last && kind == KIND_DONE))
  // only fired results are non-final
  `MTE_ASSERT(a_nonfinal_fired, (strobe && !last) |-> (kind == KIND_FIRED && !has_timer))
  // one command at most per cycle
  `MTE_ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd))

endmodule
